FILE: design/rsacbc_pkg.sv
package rsacbc_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] RESET_EXPONENT = 32'd1553;
	localparam logic [WORD_W-1:0] RESET_MODULUS = 32'd9797;

	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd1;

	localparam logic OP_NONCE = 1'b0;
	localparam logic OP_CIPHER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_BIT,
		ST_ACC_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MSEL_REDUCE,
		MSEL_ACC,
		MSEL_SQ
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     write_sq;
		logic     write_acc;
		logic     shift_exp;
		logic     commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_bit0;
	} dp_status_t;

endpackage

FILE: design/rsa_cbc_stream_decrypt.sv
// Channel | Direction | Handshake          | Payload
// request | in        | in_valid, in_stall | operation, cipher_value
// result  | out       | out_valid, out_stall | plain_value
// config  | in        | cfg_write          | cfg_index, cfg_data
//
// Each request first reduces the base modulo the modulus, then for each exponent bit up to
// its highest set bit squares (bit clear) or multiplies into the accumulator and squares
// (bit set), then finishes in the done state. The bit-serial modular multiplier takes
// one multiplier bit per cycle. Reset clears the
// controller and the chain value and restores the key registers. in_stall stays high
// until the result enters the output register; a held result keeps the next one waiting.
module rsa_cbc_stream_decrypt #(
	parameter int MOD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [rsacbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsacbc_pkg::WORD_W-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [rsacbc_pkg::WORD_W-1:0]     cipher_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rsacbc_pkg::WORD_W-1:0]     plain_value
);

	rsacbc_pkg::ctrl_cmd_t  cmd;
	rsacbc_pkg::dp_status_t status;

	rsacbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rsacbc_datapath #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.cipher_value (cipher_value),
		.cmd          (cmd),
		.status       (status),
		.plain_value  (plain_value)
	);

endmodule

FILE: design/rsacbc_modmul.sv
module rsacbc_modmul #(
	parameter int MOD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rsacbc_pkg::WORD_W-1:0] a,
	input  logic [MOD_WIDTH-1:0]          b,
	input  logic [MOD_WIDTH-1:0]          m,
	output logic                          done,
	output logic [MOD_WIDTH-1:0]          result
);

	localparam int CNT_W = $clog2(rsacbc_pkg::WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rsacbc_pkg::WORD_W - 1);

	logic [rsacbc_pkg::WORD_W-1:0] a_q;
	logic [MOD_WIDTH-1:0]          b_q;
	logic [MOD_WIDTH-1:0]          r_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [MOD_WIDTH+1:0] t0;
	logic [MOD_WIDTH+1:0] t1;
	logic [MOD_WIDTH+1:0] t2;
	logic [MOD_WIDTH+1:0] m_ext;

	// one multiplier bit per cycle, MSB first: r = 2r + bit*b, then reduce below m
	always_comb begin
		m_ext = {2'b00, m};
		t0 = {1'b0, r_q, 1'b0} + (a_q[rsacbc_pkg::WORD_W-1] ? {2'b00, b_q} : '0);
		t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
		t2 = (t1 >= m_ext) ? t1 - m_ext : t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			r_q <= t2[MOD_WIDTH-1:0];
		end
	end

	assign done = done_q;
	assign result = r_q;

endmodule

FILE: design/rsacbc_ctrl.sv
module rsacbc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  rsacbc_pkg::dp_status_t status,
	output rsacbc_pkg::ctrl_cmd_t  cmd
);

	rsacbc_pkg::state_t state_q;
	rsacbc_pkg::state_t state_d;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rsacbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = rsacbc_pkg::ST_RED_GO;
				end
			end
			rsacbc_pkg::ST_RED_GO: state_d = rsacbc_pkg::ST_RED_WAIT;
			rsacbc_pkg::ST_RED_WAIT: begin
				if (status.mul_done) begin
					state_d = rsacbc_pkg::ST_BIT;
				end
			end
			rsacbc_pkg::ST_BIT: begin
				if (status.exp_zero) begin
					state_d = rsacbc_pkg::ST_DONE;
				end else if (status.exp_bit0) begin
					state_d = rsacbc_pkg::ST_ACC_WAIT;
				end else begin
					state_d = rsacbc_pkg::ST_SQ_WAIT;
				end
			end
			rsacbc_pkg::ST_ACC_WAIT: begin
				if (status.mul_done) begin
					state_d = rsacbc_pkg::ST_SQ_GO;
				end
			end
			rsacbc_pkg::ST_SQ_GO: state_d = rsacbc_pkg::ST_SQ_WAIT;
			rsacbc_pkg::ST_SQ_WAIT: begin
				if (status.mul_done) begin
					state_d = rsacbc_pkg::ST_BIT;
				end
			end
			rsacbc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rsacbc_pkg::ST_IDLE;
				end
			end
			default: state_d = rsacbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = rsacbc_pkg::MSEL_REDUCE;
		case (state_q)
			rsacbc_pkg::ST_IDLE: cmd.load = in_valid;
			rsacbc_pkg::ST_RED_GO: cmd.mul_start = 1'b1;
			rsacbc_pkg::ST_RED_WAIT: cmd.write_sq = status.mul_done;
			rsacbc_pkg::ST_BIT: begin
				cmd.mul_start = !status.exp_zero;
				cmd.mul_sel = status.exp_bit0 ? rsacbc_pkg::MSEL_ACC : rsacbc_pkg::MSEL_SQ;
			end
			rsacbc_pkg::ST_ACC_WAIT: cmd.write_acc = status.mul_done;
			rsacbc_pkg::ST_SQ_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = rsacbc_pkg::MSEL_SQ;
			end
			rsacbc_pkg::ST_SQ_WAIT: begin
				cmd.write_sq = status.mul_done;
				cmd.shift_exp = status.mul_done;
			end
			rsacbc_pkg::ST_DONE: cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsacbc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != rsacbc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/rsacbc_datapath.sv
module rsacbc_datapath #(
	parameter int MOD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [rsacbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsacbc_pkg::WORD_W-1:0]     cfg_data,
	input  logic                              operation,
	input  logic [rsacbc_pkg::WORD_W-1:0]     cipher_value,
	input  rsacbc_pkg::ctrl_cmd_t             cmd,
	output rsacbc_pkg::dp_status_t            status,
	output logic [rsacbc_pkg::WORD_W-1:0]     plain_value
);

	localparam int W = rsacbc_pkg::WORD_W;

	logic [W-1:0]         exponent_q;
	logic [MOD_WIDTH-1:0] modulus_q;
	logic [W-1:0]         chain_q;
	logic [W-1:0]         exp_left_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] sq_q;
	logic [W-1:0]         word_q;
	logic                 op_q;
	logic [W-1:0]         plain_q;

	logic [W-1:0]         mul_a;
	logic [MOD_WIDTH-1:0] mul_b;
	logic                 mul_done;
	logic [MOD_WIDTH-1:0] mul_result;
	logic [MOD_WIDTH-1:0] dec;
	logic [W-1:0]         dec_w;

	always_comb begin
		case (cmd.mul_sel)
			rsacbc_pkg::MSEL_REDUCE: begin
				mul_a = word_q;
				mul_b = MOD_WIDTH'(1);
			end
			rsacbc_pkg::MSEL_ACC: begin
				mul_a = W'(acc_q);
				mul_b = sq_q;
			end
			rsacbc_pkg::MSEL_SQ: begin
				mul_a = W'(sq_q);
				mul_b = sq_q;
			end
			default: begin
				mul_a = word_q;
				mul_b = sq_q;
			end
		endcase
	end

	rsacbc_modmul #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (modulus_q),
		.done   (mul_done),
		.result (mul_result)
	);

	// a modulus below two is out of range and yields zero
	assign dec = (modulus_q < MOD_WIDTH'(2)) ? '0 : acc_q;
	assign dec_w = W'(dec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= rsacbc_pkg::RESET_EXPONENT;
			modulus_q <= rsacbc_pkg::RESET_MODULUS[MOD_WIDTH-1:0];
			chain_q <= '0;
		end else begin
			if (cfg_write && cfg_index == rsacbc_pkg::REG_EXPONENT) begin
				exponent_q <= cfg_data;
			end
			if (cfg_write && cfg_index == rsacbc_pkg::REG_MODULUS) begin
				modulus_q <= cfg_data[MOD_WIDTH-1:0];
			end
			if (cmd.commit) begin
				chain_q <= (op_q == rsacbc_pkg::OP_NONCE) ? dec_w : word_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= cipher_value;
			op_q <= operation;
			exp_left_q <= exponent_q;
			acc_q <= MOD_WIDTH'(1);
		end
		if (cmd.write_acc) begin
			acc_q <= mul_result;
		end
		if (cmd.write_sq) begin
			sq_q <= mul_result;
		end
		if (cmd.shift_exp) begin
			exp_left_q <= exp_left_q >> 1;
		end
		if (cmd.commit) begin
			if (op_q == rsacbc_pkg::OP_NONCE) begin
				plain_q <= dec_w;
			end else begin
				plain_q <= {{(W-8){1'b0}}, dec_w[7:0] ^ chain_q[7:0]};
			end
		end
	end

	assign status.mul_done = mul_done;
	assign status.exp_zero = (exp_left_q == '0);
	assign status.exp_bit0 = exp_left_q[0];
	assign plain_value = plain_q;

endmodule

FILE: design/rsacbc_checker.sv
module rsacbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rsacbc_pkg::WORD_W-1:0] plain_value
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("request accepted while previous one still in work");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_value))
		else $error("stalled result dropped or changed");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown with no request outstanding");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more requests outstanding than the block can hold");

endmodule

bind rsa_cbc_stream_decrypt rsacbc_checker u_rsacbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.plain_value (plain_value)
);

FILE: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W = rsacbc_pkg::WORD_W;
	localparam int CFG_IDX_W = rsacbc_pkg::CFG_IDX_W;
	localparam int MOD_W = 32;
	localparam int IDLE_LIMIT = 40000;
	localparam int RANDOM_PHASES = 10;
	localparam int REQS_PER_PHASE = 27;

	class cbc_plain_board;
		logic [WORD_W-1:0] exponent = rsacbc_pkg::RESET_EXPONENT;
		logic [WORD_W-1:0] modulus = rsacbc_pkg::RESET_MODULUS;
		logic [WORD_W-1:0] chain = '0;
		logic [WORD_W-1:0] plain_expected[$];
		int fail_count = 0;

		// square-and-multiply, base reduced first; modulus below two gives zero
		function logic [WORD_W-1:0] power_mod(logic [WORD_W-1:0] base,
				logic [WORD_W-1:0] expo, logic [WORD_W-1:0] m);
			logic [63:0] acc;
			logic [63:0] sq;
			if (m < 2)
				return '0;
			acc = 64'd1;
			sq = {32'd0, base} % {32'd0, m};
			for (int i = 0; i < WORD_W; i++) begin
				if (expo[i])
					acc = (acc * sq) % {32'd0, m};
				sq = (sq * sq) % {32'd0, m};
			end
			return acc[WORD_W-1:0];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
			if (idx == rsacbc_pkg::REG_EXPONENT)
				exponent = data;
			else if (idx == rsacbc_pkg::REG_MODULUS)
				modulus = data;
		endfunction

		function void note_request(logic op, logic [WORD_W-1:0] word);
			logic [63:0] mask;
			logic [WORD_W-1:0] dec;
			mask = (64'd1 << MOD_W) - 64'd1;
			dec = power_mod(word, exponent, modulus & mask[WORD_W-1:0]);
			if (op == rsacbc_pkg::OP_NONCE) begin
				chain = dec;
				plain_expected.push_back(dec);
			end else begin
				plain_expected.push_back({24'd0, dec[7:0] ^ chain[7:0]});
				chain = word;
			end
		endfunction

		function void check_plain(logic [WORD_W-1:0] actual);
			logic [WORD_W-1:0] want;
			if (plain_expected.size() == 0) begin
				$error("plain_value: expected none, actual %h", actual);
				fail_count++;
				return;
			end
			want = plain_expected.pop_front();
			if (actual !== want) begin
				$error("plain_value: expected %h, actual %h", want, actual);
				fail_count++;
			end
		endfunction

		function int pending();
			return plain_expected.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic operation;
	logic [WORD_W-1:0] cipher_value;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WORD_W-1:0] plain_value;

	cbc_plain_board board = new();
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int quiet_cycles = 0;

	rsa_cbc_stream_decrypt #(
		.MOD_WIDTH(MOD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.cipher_value(cipher_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.plain_value(plain_value)
	);

	always #10 clk = ~clk;

	// receiver: switch between free flow, random, periodic and solid stall windows
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= (cycle_count % 8) < 5;
			default: out_stall <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			board.check_plain(plain_value);
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [WORD_W-1:0] word);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			case ($urandom_range(0, 2))
				0: gap = 0;
				1: gap = $urandom_range(1, 40);
				default: gap = $urandom_range(41, 1200);
			endcase
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		operation = op;
		cipher_value = word;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.note_request(op, word);
		burst_left--;
	endtask

	// drop valid, then wait for every result so the block is idle
	task automatic drain_requests();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
		board.set_reg(idx, data);
	endtask

	task automatic set_key(input logic [WORD_W-1:0] expo, input logic [WORD_W-1:0] m);
		drain_requests();
		write_reg(rsacbc_pkg::REG_EXPONENT, expo);
		write_reg(rsacbc_pkg::REG_MODULUS, m);
	endtask

	task automatic run_random_phase();
		logic [WORD_W-1:0] expo;
		logic [WORD_W-1:0] m;
		logic [WORD_W-1:0] word;
		case ($urandom_range(0, 5))
			0: expo = $urandom;
			1: expo = $urandom_range(0, 15);
			default: expo = $urandom_range(1, 16'hFFFF);
		endcase
		case ($urandom_range(0, 5))
			0: m = $urandom_range(0, 3);
			1, 2: m = $urandom;
			default: m = $urandom_range(2, 16'hFFFF);
		endcase
		set_key(expo, m);
		// mostly a nonce followed by a run of cipher words
		for (int i = 0; i < REQS_PER_PHASE; i++) begin
			if ($urandom_range(0, 3) == 0)
				word = (m > 1) ? $urandom_range(0, m - 1) : $urandom;
			else
				word = $urandom;
			if (i == 0 || $urandom_range(0, 4) == 0)
				send_request(rsacbc_pkg::OP_NONCE, word);
			else
				send_request(rsacbc_pkg::OP_CIPHER, word);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = rsacbc_pkg::REG_EXPONENT;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = rsacbc_pkg::OP_NONCE;
		cipher_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset key; the first cipher word, ahead of any nonce, uses a zero chain
		send_request(rsacbc_pkg::OP_CIPHER, 32'd1234);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd0);
		send_request(rsacbc_pkg::OP_CIPHER, 32'hFFFF_FFFF);
		send_request(rsacbc_pkg::OP_NONCE, 32'd0);
		send_request(rsacbc_pkg::OP_NONCE, 32'd1);
		send_request(rsacbc_pkg::OP_NONCE, 32'd9796);
		send_request(rsacbc_pkg::OP_NONCE, 32'd9797);
		send_request(rsacbc_pkg::OP_NONCE, 32'd9798);
		send_request(rsacbc_pkg::OP_NONCE, 32'hFFFF_FFFF);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd9797);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd5000);
		send_request(rsacbc_pkg::OP_NONCE, 32'd42);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd7);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd9796);

		// zero exponent
		set_key(32'd0, rsacbc_pkg::RESET_MODULUS);
		send_request(rsacbc_pkg::OP_NONCE, 32'd77);
		send_request(rsacbc_pkg::OP_CIPHER, 32'hFFFF_FFFF);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd0);

		// modulus below two
		set_key(32'd0, 32'd0);
		send_request(rsacbc_pkg::OP_NONCE, 32'd5);
		send_request(rsacbc_pkg::OP_CIPHER, 32'hA5A5_A5A5);
		set_key(32'd3, 32'd1);
		send_request(rsacbc_pkg::OP_NONCE, 32'hFFFF_FFFF);
		send_request(rsacbc_pkg::OP_CIPHER, 32'd9);

		// widest key
		set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(rsacbc_pkg::OP_NONCE, 32'hFFFF_FFFE);
		send_request(rsacbc_pkg::OP_CIPHER, 32'hFFFF_FFFF);
		send_request(rsacbc_pkg::OP_CIPHER, 32'h1234_5678);

		// smallest legal modulus
		set_key(32'd1, 32'd2);
		send_request(rsacbc_pkg::OP_NONCE, 32'd3);
		send_request(rsacbc_pkg::OP_CIPHER, 32'hFFFF_FFFE);

		for (int p = 0; p < RANDOM_PHASES; p++)
			run_random_phase();

		drain_requests();
		repeat (2400) @(posedge clk);
		if (board.fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
